// File: src/dpfc_pkg.sv
// package: constants, state and command types for the distinct prime factor count sieve
`default_nettype none
package dpfc_pkg;

	localparam int MAX_LIMIT  = 1048576;
	localparam int COUNT_BITS = 4;
	localparam int LIMIT_W    = 21;
	localparam int THR_W      = 4;
	localparam int OUT_W      = 21;
	localparam int DEPTH      = MAX_LIMIT + 1;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int PTR_W      = IDX_W + 1;
	localparam int EXT_W      = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
	localparam int CMP_W      = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
	localparam int CNT_MAX    = (2 ** COUNT_BITS) - 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK,
		ST_CHECK,
		ST_MARK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic walk_rd;
		logic comp;
		logic prime;
		logic mark_rd;
		logic mark_end;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic j_over;
		logic i_over;
		logic i_last;
		logic rd_zero;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

// File: src/dpfc_if.sv
// interfaces: request and result channels with valid/ready handshake
`default_nettype none
interface dpfc_req_if;
	logic                         valid;
	logic                         ready;
	logic [dpfc_pkg::LIMIT_W-1:0] limit;
	logic [dpfc_pkg::THR_W-1:0]   threshold;

	modport source (output valid, output limit, output threshold, input ready);
	modport sink   (input valid, input limit, input threshold, output ready);
endinterface

interface dpfc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [dpfc_pkg::OUT_W-1:0] qualifying_count;

	modport source (output valid, output qualifying_count, input ready);
	modport sink   (input valid, input qualifying_count, output ready);
endinterface
`default_nettype wire

// File: src/distinct_prime_factor_count_sieve_unit.sv
// top level: distinct prime factor count sieve, one request at a time
// each request clears indices 2 to n of the count store, walks the indices and marks
// multiples of each prime: one store read per index walked, a read and a write per multiple
// marked (single ram port pair); a new request is taken once the previous one finishes
// the result register frees the controller while a result waits to be taken
// reset clears control state only; the count store is cleared at the start of every request
`default_nettype none
module distinct_prime_factor_count_sieve_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	dpfc_req_if.sink  request,
	dpfc_rsp_if.source result
);
	import dpfc_pkg::*;

	cmd_t  cmd;
	stat_t st;

	dpfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.st        (st),
		.cmd       (cmd)
	);

	dpfc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (request.limit),
		.threshold (request.threshold),
		.cmd       (cmd),
		.st        (st),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_count (result.qualifying_count)
	);
endmodule
`default_nettype wire

// File: src/dpfc_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module dpfc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/dpfc_ctrl.sv
// controller: sequences clear, walk, marking and result hand-off
`default_nettype none
module dpfc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output      logic            req_ready,
	input  wire dpfc_pkg::stat_t st,
	output      dpfc_pkg::cmd_t  cmd
);
	import dpfc_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (st.j_over) begin
					state_nxt = ST_WALK;
				end else begin
					cmd.clr = 1'b1;
				end
			end
			ST_WALK: begin
				if (st.i_over) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.walk_rd = 1'b1;
					state_nxt   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.rd_zero) begin
					cmd.prime = 1'b1;
					state_nxt = ST_MARK;
				end else begin
					cmd.comp = 1'b1;
					if (st.i_last) begin
						state_nxt = ST_FINISH;
					end
				end
			end
			ST_MARK: begin
				if (st.j_over) begin
					cmd.mark_end = 1'b1;
					state_nxt    = ST_WALK;
				end else begin
					cmd.mark_rd = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: src/dpfc_datapath.sv
// datapath: index counters, count store, marking pipe, tally and result register
`default_nettype none
module dpfc_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [dpfc_pkg::LIMIT_W-1:0] limit,
	input  wire logic [dpfc_pkg::THR_W-1:0]   threshold,
	input  wire dpfc_pkg::cmd_t               cmd,
	output      dpfc_pkg::stat_t              st,
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      logic [dpfc_pkg::OUT_W-1:0]   out_count
);
	import dpfc_pkg::*;

	logic [IDX_W-1:0]      n_q;
	logic [THR_W-1:0]      k_q;
	logic [PTR_W-1:0]      i_q;
	logic [PTR_W-1:0]      j_q;
	logic [OUT_W-1:0]      total_q;
	logic [OUT_W-1:0]      res_q;
	logic                  res_valid_q;
	logic                  mv_s1;
	logic [IDX_W-1:0]      ma_s1;

	logic [EXT_W-1:0]      lim_ext;
	logic [IDX_W-1:0]      n_in;
	logic [OUT_W-1:0]      total_init;
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] fin_cnt;
	logic                  qualify;
	logic                  re;
	logic [IDX_W-1:0]      raddr;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [PTR_W-1:0]      i_next;

	// limit saturates to MAX_LIMIT, the last index of the store
	assign lim_ext = EXT_W'(limit);
	assign n_in    = (lim_ext > EXT_W'(MAX_LIMIT)) ? IDX_W'(MAX_LIMIT) : IDX_W'(lim_ext);

	// indices zero and one count only when the threshold is zero
	always_comb begin
		total_init = '0;
		if (threshold == '0) begin
			total_init = (n_in == '0) ? OUT_W'(1) : OUT_W'(2);
		end
	end

	assign i_next  = i_q + PTR_W'(1);
	assign fin_cnt = (rdata == '0) ? COUNT_BITS'(1) : rdata;
	assign qualify = CMP_W'(fin_cnt) >= CMP_W'(k_q);

	assign st.j_over   = j_q > PTR_W'(n_q);
	assign st.i_over   = i_q > PTR_W'(n_q);
	assign st.i_last   = i_q == PTR_W'(n_q);
	assign st.rd_zero  = rdata == '0;
	assign st.out_busy = res_valid_q && !out_ready;

	// read port: walk probe, composite prefetch or marking read
	always_comb begin
		re    = 1'b0;
		raddr = j_q[IDX_W-1:0];
		if (cmd.walk_rd) begin
			re    = 1'b1;
			raddr = i_q[IDX_W-1:0];
		end else if (cmd.comp && !st.i_last) begin
			re    = 1'b1;
			raddr = i_next[IDX_W-1:0];
		end else if (cmd.mark_rd) begin
			re    = 1'b1;
			raddr = j_q[IDX_W-1:0];
		end
	end

	// write port: clearing, or saturating increment in the cycle after the marking read
	always_comb begin
		we    = 1'b0;
		waddr = ma_s1;
		wdata = '0;
		if (cmd.clr) begin
			we    = 1'b1;
			waddr = j_q[IDX_W-1:0];
		end else if (mv_s1) begin
			we    = 1'b1;
			wdata = (rdata == COUNT_BITS'(CNT_MAX)) ? rdata : rdata + COUNT_BITS'(1);
		end
	end

	dpfc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			mv_s1 <= cmd.mark_rd;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ma_s1 <= j_q[IDX_W-1:0];
		if (cmd.load) begin
			n_q     <= n_in;
			k_q     <= threshold;
			i_q     <= PTR_W'(2);
			j_q     <= PTR_W'(2);
			total_q <= total_init;
		end
		if (cmd.clr) begin
			j_q <= j_q + PTR_W'(1);
		end
		if (cmd.comp) begin
			i_q <= i_next;
			if (qualify) begin
				total_q <= total_q + OUT_W'(1);
			end
		end
		if (cmd.prime) begin
			j_q <= i_q;
			if (qualify) begin
				total_q <= total_q + OUT_W'(1);
			end
		end
		if (cmd.mark_rd) begin
			j_q <= j_q + i_q;
		end
		if (cmd.mark_end) begin
			i_q <= i_next;
		end
		if (cmd.out_load) begin
			res_q <= total_q;
		end
	end

	assign out_valid = res_valid_q;
	assign out_count = res_q;
endmodule
`default_nettype wire

// File: tb/sieve_count_checker.sv
// checker: predicts the qualifying count of each request and compares it with the results
`default_nettype none
module sieve_count_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	dpfc_req_if       req,
	dpfc_rsp_if       rsp,
	output int        failures,
	output int        pending
);
	import dpfc_pkg::*;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [THR_W-1:0]   threshold;
		logic [OUT_W-1:0]   count;
	} sieve_answer_t;

	bit [COUNT_BITS-1:0] factor_tally [0:MAX_LIMIT];
	sieve_answer_t       awaited_counts [$];
	int                  fail_count = 0;
	int                  awaited_size = 0;

	assign failures = fail_count;
	assign pending  = awaited_size;

	function automatic logic [OUT_W-1:0] count_qualifying(input logic [LIMIT_W-1:0] lim,
			input logic [THR_W-1:0] thr);
		int unsigned n;
		int unsigned i;
		int unsigned j;
		int unsigned total;
		n = (lim > MAX_LIMIT) ? MAX_LIMIT : lim;
		for (i = 0; i <= n; i++)
			factor_tally[i] = '0;
		// an index still at zero when reached is prime
		for (i = 2; i <= n; i++) begin
			if (factor_tally[i] == 0) begin
				for (j = i; j <= n; j += i) begin
					if (factor_tally[j] != CNT_MAX)
						factor_tally[j] = factor_tally[j] + 1'b1;
				end
			end
		end
		total = 0;
		for (i = 0; i <= n; i++) begin
			if (factor_tally[i] >= thr)
				total++;
		end
		return total[OUT_W-1:0];
	endfunction

	always @(posedge clk) begin
		sieve_answer_t head;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_counts.size() == 0) begin
					$display("%0t unexpected result: expected none, actual qualifying_count %0d",
						$time, rsp.qualifying_count);
					fail_count <= fail_count + 1;
				end else begin
					head = awaited_counts.pop_front();
					if (rsp.qualifying_count !== head.count) begin
						$display({"%0t qualifying_count mismatch (limit %0d threshold %0d): ",
							"expected %0d actual %0d"},
							$time, head.limit, head.threshold, head.count,
							rsp.qualifying_count);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_counts.push_back({req.limit, req.threshold,
					count_qualifying(req.limit, req.threshold)});
			awaited_size <= awaited_counts.size();
		end
	end

endmodule
`default_nettype wire

// File: tb/tb_distinct_prime_factor_count_sieve_unit.sv
// testbench top: request stimulus with bursts and result back-pressure around the sieve unit
`default_nettype none
module tb_distinct_prime_factor_count_sieve_unit;
	import dpfc_pkg::*;

	localparam int CYCLE_LIMIT = 40000000;
	localparam int HOLD_CYCLES = 300000;
	localparam int HOLD_AFTER  = 30;
	localparam int RANDOM_REQS = 100;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [THR_W-1:0]   threshold;
	} sieve_req_t;

	typedef enum {SINK_DRAIN, SINK_FLICKER, SINK_STALL} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   pending;
	int   accepted = 0;
	int   cycles = 0;

	dpfc_req_if req_ch ();
	dpfc_rsp_if rsp_ch ();

	distinct_prime_factor_count_sieve_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (rsp_ch)
	);

	sieve_count_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic offer(input sieve_req_t item);
		req_ch.valid     <= 1'b1;
		req_ch.limit     <= item.limit;
		req_ch.threshold <= item.threshold;
		do @(posedge clk); while (!req_ch.ready);
		accepted <= accepted + 1;
	endtask

	// result side: own stall pattern, plus one long hold-off to back the block up
	initial begin
		bit         held;
		sink_mode_t mode;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && accepted >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = sink_mode_t'($urandom_range(0, 2));
			case (mode)
				SINK_DRAIN: begin
					rsp_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 40)) @(posedge clk);
				end
				SINK_FLICKER: begin
					repeat ($urandom_range(1, 30)) begin
						rsp_ch.ready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
				end
				default: begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 15)) @(posedge clk);
				end
			endcase
		end
	end

	initial begin
		sieve_req_t       plan [$];
		logic [LIMIT_W-1:0] lim;
		logic [THR_W-1:0]   thr;
		int               idx;
		int               burst;
		int               gap;
		int               pick;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.limit     <= '0;
		req_ch.threshold <= '0;

		// limit of zero, indices zero and one, small primes, powers of two and primorials
		plan.push_back({21'd0, 4'd0});
		plan.push_back({21'd0, 4'd1});
		plan.push_back({21'd1, 4'd0});
		plan.push_back({21'd1, 4'd15});
		plan.push_back({21'd2, 4'd0});
		plan.push_back({21'd2, 4'd1});
		plan.push_back({21'd2, 4'd2});
		plan.push_back({21'd16, 4'd1});
		plan.push_back({21'd30, 4'd3});
		plan.push_back({21'd64, 4'd15});
		plan.push_back({21'd100, 4'd2});
		plan.push_back({21'd210, 4'd4});
		plan.push_back({21'd2310, 4'd5});
		plan.push_back({21'd30030, 4'd6});
		// all limit bits set: saturates to the largest limit
		plan.push_back({21'h1FFFFF, 4'd7});

		for (idx = 0; idx < RANDOM_REQS; idx++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				lim = LIMIT_W'($urandom_range(0, 64));
			else if (pick < 95)
				lim = LIMIT_W'($urandom_range(65, 2000));
			else
				lim = LIMIT_W'($urandom_range(2001, 20000));
			if ($urandom_range(0, 2) != 0)
				thr = THR_W'($urandom_range(0, 4));
			else
				thr = THR_W'($urandom_range(0, 15));
			plan.push_back({lim, thr});
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < plan.size()) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && idx < plan.size()) begin
				offer(plan[idx]);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
